// ===== rtl/core/icmb_pkg.sv =====
// Shared types and defaults for the intercore mailbox and spinlock block.
package icmb_pkg;

  localparam int unsigned MBOX_DEPTH_DEF = 8;
  localparam int unsigned LOCK_COUNT_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LOCKIDX_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_STATUS  = 3'd2,
    FUNC_ACQUIRE = 3'd3,
    FUNC_RELEASE = 3'd4
  } func_e;

endpackage

// ===== rtl/core/intercore_mailbox_and_spinlocks_core.sv =====
// Two-core mailbox: two outgoing word FIFOs in one synchronous RAM plus a spinlock bank.
//
// An item accepted at a clock edge (start_i high, busy_o
// low) has its result on the result ports, marked by done_o, for exactly the following
// cycle. busy_o stays low, so a new item can be issued in every cycle. The mailbox words
// sit in a RAM with a registered read; a pop reads its word at the accept edge
// and the word appears with the result. Pointers, fill counts and lock bits are flops;
// the RAM needs no clearing after reset. The receiver cannot stall, so results must be
// taken in the cycle done_o is high.
module intercore_mailbox_and_spinlocks_core #(
  parameter int unsigned MAILBOX_DEPTH = icmb_pkg::MBOX_DEPTH_DEF,
  parameter int unsigned LOCK_COUNT    = icmb_pkg::LOCK_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [icmb_pkg::FUNC_W-1:0]    func_i,
  input  logic                           core_sel_i,
  input  logic [icmb_pkg::WORD_W-1:0]    push_data_i,
  input  logic [icmb_pkg::LOCKIDX_W-1:0] lock_index_i,
  output logic                           done_o,
  output logic                           success_o,
  output logic [icmb_pkg::WORD_W-1:0]    pop_data_o,
  output logic                           own_empty_o,
  output logic                           own_full_o,
  output logic                           incoming_valid_o
);
  import icmb_pkg::*;

  localparam int unsigned PW   = $clog2(MAILBOX_DEPTH);
  localparam int unsigned CW   = $clog2(MAILBOX_DEPTH + 1);
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned LIW  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int unsigned LXW  = LOCKIDX_W + 2;

  logic [WORD_W-1:0] mem_q [2**AW];
  logic [WORD_W-1:0] rdata_q;

  logic [PW-1:0] rp_q [2];
  logic [PW-1:0] rp_d [2];
  logic [PW-1:0] wp_q [2];
  logic [PW-1:0] wp_d [2];
  logic [CW-1:0] fill_q [2];
  logic [CW-1:0] fill_d [2];
  logic [LOCK_COUNT-1:0] lock_q, lock_d;

  logic done_q, success_q, success_d, popped_q, popped_d;
  logic own_empty_q, own_full_q, in_valid_q;

  logic          accept;
  logic          own, other;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [LXW-1:0] lk_ext;
  logic          lk_ok;
  logic [LIW-1:0] lk;
  func_e         func;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(MAILBOX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign own     = core_sel_i;
  assign other   = ~core_sel_i;
  assign func    = func_e'(func_i);
  assign lk_ext  = {2'b00, lock_index_i};
  assign lk_ok   = lk_ext < LXW'(LOCK_COUNT);
  assign lk      = lk_ext[LIW-1:0];
  assign wr_addr = {own, wp_q[own]};
  assign rd_addr = {other, rp_q[other]};

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    lock_d    = lock_q;
    success_d = 1'b0;
    popped_d  = 1'b0;
    wr_en     = 1'b0;
    unique case (func)
      FUNC_PUSH: begin
        if (fill_q[own] < CW'(MAILBOX_DEPTH)) begin
          wr_en        = 1'b1;
          wp_d[own]    = next_ptr(wp_q[own]);
          fill_d[own]  = fill_q[own] + 1'b1;
          success_d    = 1'b1;
        end
      end
      FUNC_POP: begin
        if (fill_q[other] != '0) begin
          rp_d[other]   = next_ptr(rp_q[other]);
          fill_d[other] = fill_q[other] - 1'b1;
          popped_d      = 1'b1;
          success_d     = 1'b1;
        end
      end
      FUNC_ACQUIRE: begin
        if (lk_ok && !lock_q[lk]) begin
          lock_d[lk] = 1'b1;
          success_d  = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (lk_ok) begin
          lock_d[lk] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Mailbox RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[wr_addr] <= push_data_i;
    end
    if (accept) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '{default: '0};
      wp_q        <= '{default: '0};
      fill_q      <= '{default: '0};
      lock_q      <= '0;
      done_q      <= 1'b0;
      success_q   <= 1'b0;
      popped_q    <= 1'b0;
      own_empty_q <= 1'b0;
      own_full_q  <= 1'b0;
      in_valid_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        rp_q        <= rp_d;
        wp_q        <= wp_d;
        fill_q      <= fill_d;
        lock_q      <= lock_d;
        success_q   <= success_d;
        popped_q    <= popped_d;
        own_empty_q <= (fill_d[own] == '0);
        own_full_q  <= (fill_d[own] >= CW'(MAILBOX_DEPTH));
        in_valid_q  <= (fill_d[other] != '0);
      end
    end
  end

  assign done_o           = done_q;
  assign success_o        = success_q;
  assign pop_data_o       = popped_q ? rdata_q : '0;
  assign own_empty_o      = own_empty_q;
  assign own_full_o       = own_full_q;
  assign incoming_valid_o = in_valid_q;

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("result strobe missing after accepted item");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result strobe without accepted item");

  a_empty_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(own_empty_o && own_full_o)) else $error("FIFO reported empty and full");

  a_pop_data_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pop_data_o != '0) |-> success_o) else $error("pop data without success");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= CW'(MAILBOX_DEPTH)) && (fill_q[1] <= CW'(MAILBOX_DEPTH)))
    else $error("fill count beyond depth");
`endif

endmodule
